FILE: rtl/dhd_pkg.sv
// ----------------------------------------------------------------------------
// dhd_pkg
// Shared types and constants for the detection head decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dhd_pkg;

  localparam int NumClasses = 80;
  localparam int BoxCount   = 4;
  localparam int PosW       = 7;
  localparam int ValueW     = 24;
  localparam int ScoreW     = 23;
  localparam int ClassW     = 8;
  localparam int OutW       = 20;
  localparam int ThrW       = 13;
  localparam int PadW       = 10;
  localparam int InvW       = 16;
  localparam int MaskW      = 80;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;
  localparam int QueueDepth = 4;

  localparam logic [PosW-1:0] PosMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    RegScoreThreshold = 3'd0,
    RegAllowEvery     = 3'd1,
    RegAllowedLow     = 3'd2,
    RegAllowedHigh    = 3'd3,
    RegPadLeft        = 3'd4,
    RegPadTop         = 3'd5,
    RegInverseScale   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ThrW-1:0]  score_threshold;
    logic             allow_every_class;
    logic [MaskW-1:0] allowed_classes;
    logic [PadW-1:0]  pad_left;
    logic [PadW-1:0]  pad_top;
    logic [InvW-1:0]  inverse_scale;
  } cfg_t;

  // One accepted detection, handed from front to back
  typedef struct packed {
    logic signed [ValueW-1:0] cx;
    logic signed [ValueW-1:0] cy;
    logic signed [ValueW-1:0] w;
    logic signed [ValueW-1:0] h;
    logic [ScoreW-1:0]        score;
    logic signed [ClassW-1:0] cls;
  } det_t;

endpackage

`default_nettype wire

FILE: rtl/dhd_front.sv
// ----------------------------------------------------------------------------
// dhd_front
// Per-anchor value intake: stores box values, tracks best class score and
// decides on the last value whether the anchor yields a detection.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhd_front (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire dhd_pkg::cfg_t                     cfg_i,
  input  wire logic                              accept_i,
  input  wire logic signed [dhd_pkg::ValueW-1:0] head_value_i,
  input  wire logic                              anchor_end_i,
  output logic                                   push_o,
  output dhd_pkg::det_t                          det_o
);
  import dhd_pkg::*;

  logic [PosW-1:0]          pos_q, pos_d;
  logic signed [ValueW-1:0] best_score_q, best_score_d, best_score_new;
  logic signed [ClassW-1:0] best_class_q, best_class_d, best_class_new;
  logic signed [ValueW-1:0] box_q [BoxCount];
  logic signed [ValueW-1:0] box_new [BoxCount];

  logic                     is_box, is_score, take;
  logic signed [ClassW-1:0] class_cur;
  logic                     score_ok, class_ok;

  assign is_box    = pos_q < PosW'(BoxCount);
  assign is_score  = !is_box && (pos_q < PosW'(BoxCount + NumClasses));
  assign class_cur = ClassW'(pos_q) - ClassW'(BoxCount);
  assign take      = is_score && (head_value_i > best_score_q);

  always_comb begin
    for (int i = 0; i < BoxCount; i++) begin
      box_new[i] = box_q[i];
    end
    if (is_box) begin
      box_new[pos_q[1:0]] = head_value_i;
    end
    best_score_new = take ? head_value_i : best_score_q;
    best_class_new = take ? class_cur : best_class_q;
  end

  // best score never goes negative, so an unsigned compare is exact
  assign score_ok = best_score_new >= ValueW'(cfg_i.score_threshold);
  assign class_ok = cfg_i.allow_every_class ||
                    (!best_class_new[ClassW-1] &&
                     cfg_i.allowed_classes[best_class_new[PosW-1:0]]);

  assign push_o = accept_i && anchor_end_i && score_ok && class_ok;

  assign det_o.cx    = box_new[0];
  assign det_o.cy    = box_new[1];
  assign det_o.w     = box_new[2];
  assign det_o.h     = box_new[3];
  assign det_o.score = best_score_new[ScoreW-1:0];
  assign det_o.cls   = best_class_new;

  always_comb begin
    pos_d        = pos_q;
    best_score_d = best_score_q;
    best_class_d = best_class_q;
    if (accept_i) begin
      if (anchor_end_i) begin
        pos_d        = '0;
        best_score_d = '0;
        best_class_d = '1;
      end else begin
        pos_d        = (pos_q == PosMax) ? pos_q : pos_q + 1'b1;
        best_score_d = best_score_new;
        best_class_d = best_class_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q        <= '0;
      best_score_q <= '0;
      best_class_q <= '1;
    end else begin
      pos_q        <= pos_d;
      best_score_q <= best_score_d;
      best_class_q <= best_class_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && is_box) begin
      box_q[pos_q[1:0]] <= head_value_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dhd_queue.sv
// ----------------------------------------------------------------------------
// dhd_queue
// Short FIFO of accepted detections between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire dhd_pkg::det_t det_i,
  output logic               full_o,
  output logic               valid_o,
  input  wire logic          pop_i,
  output dhd_pkg::det_t      det_o
);
  import dhd_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  det_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign det_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= det_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth)) else $error("queue count out of range");

  a_ptr_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || full_o) |-> wr_q == rd_q) else $error("queue pointers diverged");

endmodule

`default_nettype wire

FILE: rtl/dhd_back.sv
// ----------------------------------------------------------------------------
// dhd_back
// Letterbox undo: pad offset, reciprocal-scale multiply, round and saturate,
// with an output register that holds a result while the consumer stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dhd_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire dhd_pkg::cfg_t cfg_i,
  input  wire logic          q_valid_i,
  input  wire dhd_pkg::det_t q_det_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic signed [dhd_pkg::OutW-1:0]   box_left_o,
  output logic signed [dhd_pkg::OutW-1:0]   box_top_o,
  output logic signed [dhd_pkg::OutW-1:0]   box_width_o,
  output logic signed [dhd_pkg::OutW-1:0]   box_height_o,
  output logic [dhd_pkg::ScoreW-1:0]        confidence_o,
  output logic signed [dhd_pkg::ClassW-1:0] class_index_o
);
  import dhd_pkg::*;

  localparam int DiffW   = ValueW + 3;
  localparam int MulPosW = DiffW + InvW + 1;
  localparam int MulSzW  = ValueW + InvW + 1;
  localparam int SumW    = MulPosW + 1;
  localparam logic signed [SumW-1:0] HalfPos = SumW'(1) <<< 20;
  localparam logic signed [SumW-1:0] HalfSz  = SumW'(1) <<< 19;
  localparam logic signed [SumW-1:0] OutMax  = SumW'((1 << (OutW - 1)) - 1);
  localparam logic signed [SumW-1:0] OutMin  = -(SumW'(1) <<< (OutW - 1));

  function automatic logic signed [OutW-1:0] sat_out(input logic signed [SumW-1:0] r);
    logic signed [OutW-1:0] res;
    if (r > OutMax) begin
      res = OutMax[OutW-1:0];
    end else if (r < OutMin) begin
      res = OutMin[OutW-1:0];
    end else begin
      res = r[OutW-1:0];
    end
    return res;
  endfunction

  logic                     s1_v_q, s2_v_q, out_v_q;
  logic                     s1_rdy, s2_rdy, out_rdy;
  logic signed [DiffW-1:0]  dx_q, dy_q, dx_d, dy_d;
  logic signed [ValueW-1:0] w_q, h_q;
  logic [ScoreW-1:0]        sc1_q, sc2_q, sc3_q;
  logic signed [ClassW-1:0] cl1_q, cl2_q, cl3_q;

  logic signed [InvW:0]      inv_s;
  logic signed [MulPosW-1:0] pl_d, pt_d, pl_q, pt_q;
  logic signed [MulSzW-1:0]  pw_d, ph_d, pw_q, ph_q;
  logic signed [SumW-1:0]    rl, rt, rw, rh;
  logic signed [OutW-1:0]    left_q, top_q, width_q, height_q;

  assign out_rdy = !out_v_q || !out_stall_i;
  assign s2_rdy  = !s2_v_q || out_rdy;
  assign s1_rdy  = !s1_v_q || s2_rdy;
  assign q_pop_o = q_valid_i && s1_rdy;

  // 2*centre - size - 2*pad, all in Q12
  assign dx_d = (DiffW'(q_det_i.cx) <<< 1) - DiffW'(q_det_i.w)
              - DiffW'({cfg_i.pad_left, 13'b0});
  assign dy_d = (DiffW'(q_det_i.cy) <<< 1) - DiffW'(q_det_i.h)
              - DiffW'({cfg_i.pad_top, 13'b0});

  assign inv_s = $signed({1'b0, cfg_i.inverse_scale});
  assign pl_d  = dx_q * inv_s;
  assign pt_d  = dy_q * inv_s;
  assign pw_d  = w_q * inv_s;
  assign ph_d  = h_q * inv_s;

  // round half up, then floor
  assign rl = (SumW'(pl_q) + HalfPos) >>> 21;
  assign rt = (SumW'(pt_q) + HalfPos) >>> 21;
  assign rw = (SumW'(pw_q) + HalfSz) >>> 20;
  assign rh = (SumW'(ph_q) + HalfSz) >>> 20;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_v_q <= q_valid_i;
      end
      if (s2_rdy) begin
        s2_v_q <= s1_v_q;
      end
      if (out_rdy) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      w_q   <= q_det_i.w;
      h_q   <= q_det_i.h;
      sc1_q <= q_det_i.score;
      cl1_q <= q_det_i.cls;
    end
    if (s1_v_q && s2_rdy) begin
      pl_q  <= pl_d;
      pt_q  <= pt_d;
      pw_q  <= pw_d;
      ph_q  <= ph_d;
      sc2_q <= sc1_q;
      cl2_q <= cl1_q;
    end
    if (s2_v_q && out_rdy) begin
      left_q   <= sat_out(rl);
      top_q    <= sat_out(rt);
      width_q  <= sat_out(rw);
      height_q <= sat_out(rh);
      sc3_q    <= sc2_q;
      cl3_q    <= cl2_q;
    end
  end

  assign out_valid_o   = out_v_q;
  assign box_left_o    = left_q;
  assign box_top_o     = top_q;
  assign box_width_o   = width_q;
  assign box_height_o  = height_q;
  assign confidence_o  = sc3_q;
  assign class_index_o = cl3_q;

endmodule

`default_nettype wire

FILE: rtl/detection_head_decode.sv
// A result passes through the detection queue, the stage-one and product registers
//   and the output register after the edge that transfers the anchor's last value.
// Throughput: one head value per cycle while the input is not stalled; one result per anchor at most.
// The input stalls only when the four-entry detection queue is full.
// Reset (async, active low) restores register defaults and clears anchor state;
//   box value storage is not reset.
`timescale 1ns / 1ps
`default_nettype none

module detection_head_decode (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [dhd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  wire logic [dhd_pkg::CfgDataW-1:0]        cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic signed [dhd_pkg::ValueW-1:0]   head_value_i,
  input  wire logic                                anchor_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [dhd_pkg::OutW-1:0]          box_left_o,
  output logic signed [dhd_pkg::OutW-1:0]          box_top_o,
  output logic signed [dhd_pkg::OutW-1:0]          box_width_o,
  output logic signed [dhd_pkg::OutW-1:0]          box_height_o,
  output logic [dhd_pkg::ScoreW-1:0]               confidence_o,
  output logic signed [dhd_pkg::ClassW-1:0]        class_index_o
);
  import dhd_pkg::*;

  cfg_t cfg_q;
  logic accept, push, q_full, q_valid, q_pop;
  det_t front_det, q_det;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold   <= ThrW'(1024);
      cfg_q.allow_every_class <= 1'b1;
      cfg_q.allowed_classes   <= '0;
      cfg_q.pad_left          <= '0;
      cfg_q.pad_top           <= '0;
      cfg_q.inverse_scale     <= InvW'(4096);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegScoreThreshold: cfg_q.score_threshold   <= cfg_data_i[ThrW-1:0];
        RegAllowEvery:     cfg_q.allow_every_class <= cfg_data_i[0];
        RegAllowedLow:     cfg_q.allowed_classes[63:0] <= cfg_data_i;
        RegAllowedHigh:    cfg_q.allowed_classes[MaskW-1:64] <= cfg_data_i[MaskW-65:0];
        RegPadLeft:        cfg_q.pad_left          <= cfg_data_i[PadW-1:0];
        RegPadTop:         cfg_q.pad_top           <= cfg_data_i[PadW-1:0];
        RegInverseScale:   cfg_q.inverse_scale     <= cfg_data_i[InvW-1:0];
        default: ;
      endcase
    end
  end

  dhd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .head_value_i (head_value_i),
    .anchor_end_i (anchor_end_i),
    .push_o       (push),
    .det_o        (front_det)
  );

  dhd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .det_i   (front_det),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .det_o   (q_det)
  );

  dhd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_det_i       (q_det),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .box_left_o    (box_left_o),
    .box_top_o     (box_top_o),
    .box_width_o   (box_width_o),
    .box_height_o  (box_height_o),
    .confidence_o  (confidence_o),
    .class_index_o (class_index_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams anchors of head values into the detection head decoder and checks
// every emitted detection against a cycle-free predictor of the decode: best
// class search, threshold and class filtering, letterbox undo with rounding
// and saturation. Sender and receiver idle at random but in one phase. The block
// is reconfigured between phases, only once all its output has drained.
// ----------------------------------------------------------------------------

module testbench;
  import dhd_pkg::*;

  localparam int     PhaseItems   = 285;
  localparam int     RandPhases   = 6;
  localparam int     IdlePct      = 33;
  localparam int     SettleCycles = 16;
  localparam int     FullAnchor   = BoxCount + NumClasses;
  localparam longint OutMax       = (longint'(1) << (OutW - 1)) - 1;
  localparam longint OutMin       = -(longint'(1) << (OutW - 1));
  localparam longint PadUnit      = longint'(2) << 12;  // doubled pixel in Q12
  localparam int     EdgeShift    = 21;                 // doubled Q24 -> Q4
  localparam int     SizeShift    = 20;                 // Q24 -> Q4

  typedef struct {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } head_item_t;

  typedef struct {
    logic signed [OutW-1:0]   left;
    logic signed [OutW-1:0]   top;
    logic signed [OutW-1:0]   width;
    logic signed [OutW-1:0]   height;
    logic [ScoreW-1:0]        conf;
    logic signed [ClassW-1:0] cls;
  } detection_t;

  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_valid_i  = 1'b0;
  logic                     cfg_ready_o;
  cfg_idx_e                 cfg_index_i  = RegScoreThreshold;
  logic [CfgDataW-1:0]      cfg_data_i   = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_stall_o;
  logic signed [ValueW-1:0] head_value_i = '0;
  logic                     anchor_end_i = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i  = 1'b0;
  logic signed [OutW-1:0]   box_left_o;
  logic signed [OutW-1:0]   box_top_o;
  logic signed [OutW-1:0]   box_width_o;
  logic signed [OutW-1:0]   box_height_o;
  logic [ScoreW-1:0]        confidence_o;
  logic signed [ClassW-1:0] class_index_o;

  detection_head_decode uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .head_value_i (head_value_i),
    .anchor_end_i (anchor_end_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o),
    .confidence_o (confidence_o),
    .class_index_o(class_index_o)
  );

  always #4 clk_i = ~clk_i;

  // Predictor copy of the register file
  logic [ThrW-1:0]  thr_reg    = 13'd1024;
  logic             every_reg  = 1'b1;
  logic [MaskW-1:0] allow_mask = '0;
  logic [PadW-1:0]  pad_x      = '0;
  logic [PadW-1:0]  pad_y      = '0;
  logic [InvW-1:0]  inv_scale  = 16'd4096;

  // Predictor copy of the anchor state
  logic [PosW-1:0]          anchor_pos = '0;
  logic signed [ValueW-1:0] best_score = '0;
  logic signed [ClassW-1:0] best_class = -8'sd1;
  logic signed [ValueW-1:0] box_val [BoxCount];

  head_item_t head_stream [$];
  detection_t pending_dets [$];
  head_item_t cur_item;
  detection_t got_det;
  int         error_count = 0;
  int         gen_count   = 0;
  logic       no_idle     = 1'b0;

  function automatic logic signed [OutW-1:0] round_clip(longint prod, int sh);
    longint r;
    r = (prod + (longint'(1) << (sh - 1))) >>> sh;
    if (r > OutMax) r = OutMax;
    if (r < OutMin) r = OutMin;
    return r[OutW-1:0];
  endfunction

  function automatic logic class_ok(logic signed [ClassW-1:0] c);
    if (every_reg) return 1'b1;
    if (c < 0) return 1'b0;
    return allow_mask[c];
  endfunction

  task automatic decode_value(head_item_t it);
    detection_t det;
    longint     inv;
    if (anchor_pos < BoxCount) begin
      box_val[anchor_pos[1:0]] = it.value;
    end else if (anchor_pos < FullAnchor) begin
      if (it.value > best_score) begin
        best_score = it.value;
        best_class = ClassW'(anchor_pos) - ClassW'(BoxCount);
      end
    end
    if (anchor_pos != PosMax) anchor_pos++;
    if (it.last) begin
      if (int'(best_score) >= int'(thr_reg) && class_ok(best_class)) begin
        inv = longint'(inv_scale);
        det.left   = round_clip((2 * longint'(box_val[0]) - longint'(box_val[2])
                                 - longint'(pad_x) * PadUnit) * inv, EdgeShift);
        det.top    = round_clip((2 * longint'(box_val[1]) - longint'(box_val[3])
                                 - longint'(pad_y) * PadUnit) * inv, EdgeShift);
        det.width  = round_clip(longint'(box_val[2]) * inv, SizeShift);
        det.height = round_clip(longint'(box_val[3]) * inv, SizeShift);
        det.conf   = best_score[ScoreW-1:0];
        det.cls    = best_class;
        pending_dets.insert(pending_dets.size(), det);
      end
      anchor_pos = '0;
      best_score = '0;
      best_class = -8'sd1;
    end
  endtask

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Driver: one item in flight, held while stalled
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) decode_value(cur_item);
      if (!in_valid_i || !in_stall_o) begin
        if (head_stream.size() != 0 && (no_idle || $urandom_range(99) >= IdlePct)) begin
          cur_item = head_stream.pop_front();
          in_valid_i   <= 1'b1;
          head_value_i <= cur_item.value;
          anchor_end_i <= cur_item.last;
        end else begin
          in_valid_i   <= 1'b0;
          head_value_i <= ValueW'($urandom);
          anchor_end_i <= 1'($urandom);
        end
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_dets.size() == 0) begin
          $error("detection transfer with none expected: class %0d", class_index_o);
          error_count++;
        end else begin
          got_det = pending_dets.pop_front();
          check_field("box_left", got_det.left, box_left_o);
          check_field("box_top", got_det.top, box_top_o);
          check_field("box_width", got_det.width, box_width_o);
          check_field("box_height", got_det.height, box_height_o);
          check_field("confidence", got_det.conf, confidence_o);
          check_field("class_index", got_det.cls, class_index_o);
        end
      end
      out_stall_i <= !no_idle && ($urandom_range(99) < IdlePct);
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegScoreThreshold: thr_reg = data[ThrW-1:0];
      RegAllowEvery:     every_reg = data[0];
      RegAllowedLow:     allow_mask[63:0] = data;
      RegAllowedHigh:    allow_mask[MaskW-1:64] = data[MaskW-65:0];
      RegPadLeft:        pad_x = data[PadW-1:0];
      RegPadTop:         pad_y = data[PadW-1:0];
      RegInverseScale:   inv_scale = data[InvW-1:0];
      default: ;
    endcase
  endtask

  // Upper bits above each register carry junk; the block must ignore them
  task automatic load_config(logic [ThrW-1:0] thr, logic every, logic [63:0] lo,
                             logic [15:0] hi, logic [PadW-1:0] pl,
                             logic [PadW-1:0] pt, logic [InvW-1:0] inv);
    logic [CfgDataW-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(RegScoreThreshold, {junk[63:ThrW], thr});
    write_reg(RegAllowEvery, {junk[63:1], every});
    write_reg(RegAllowedLow, lo);
    write_reg(RegAllowedHigh, {junk[63:16], hi});
    write_reg(RegPadLeft, {junk[63:PadW], pl});
    write_reg(RegPadTop, {junk[63:PadW], pt});
    write_reg(RegInverseScale, {junk[63:InvW], inv});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic rand_config();
    logic [ThrW-1:0] thr;
    logic [63:0]     lo;
    logic [15:0]     hi;
    logic [PadW-1:0] pl, pt;
    logic [InvW-1:0] inv;
    case ($urandom_range(5))
      0:       thr = '0;
      1:       thr = 13'd4096;
      2:       thr = '1;
      default: thr = ThrW'($urandom_range(0, 4096));
    endcase
    lo = ($urandom_range(7) == 0) ? '1 : {$urandom, $urandom};
    hi = ($urandom_range(7) == 0) ? '1 : 16'($urandom);
    pl = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 64));
    pt = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(0, 64));
    case ($urandom_range(7))
      0:       inv = 16'd1;
      1:       inv = '1;
      2:       inv = '0;
      default: inv = InvW'($urandom_range(2048, 12288));
    endcase
    load_config(thr, 1'($urandom), lo, hi, pl, pt, inv);
  endtask

  task automatic add_item(int v, logic last);
    head_item_t it;
    it.value = v[ValueW-1:0];
    it.last  = last;
    head_stream.insert(head_stream.size(), it);
    gen_count++;
  endtask

  function automatic int gen_box(int mode, int idx);
    if (mode < 6) return (idx < 2) ? $urandom_range(0, 640 * 4096) : $urandom_range(0, 320 * 4096);
    if (mode < 8) return int'($urandom);
    case ($urandom_range(3))
      0:       return 8388607;
      1:       return -8388608;
      2:       return 0;
      default: return -1;
    endcase
  endfunction

  function automatic int gen_score(int mode);
    case (mode)
      0:       return int'($urandom);
      1:       return $urandom_range(0, 6000);
      2:       return -int'($urandom_range(0, 200000));
      default: return $urandom_range(0, 4) * 1024;  // many ties
    endcase
  endfunction

  task automatic add_anchor(int n, int box_mode, int score_mode);
    int v;
    for (int i = 0; i < n; i++) begin
      v = (i < BoxCount) ? gen_box(box_mode, i) : gen_score(score_mode);
      add_item(v, i == n - 1);
    end
  endtask

  // Box entries are all written by the first directed anchor, so short
  // anchors never read an unwritten entry
  task automatic add_random_anchor();
    int sel, n;
    sel = $urandom_range(99);
    if (sel < 66) begin
      add_anchor(BoxCount + $urandom_range(1, 12), $urandom_range(9), $urandom_range(3));
    end else if (sel < 78) begin
      add_anchor($urandom_range(1, BoxCount), $urandom_range(9), $urandom_range(3));
    end else if (sel < 86) begin
      add_anchor(FullAnchor, $urandom_range(9), $urandom_range(3));
    end else if (sel < 90) begin
      add_anchor($urandom_range(FullAnchor + 1, 140), $urandom_range(9), $urandom_range(3));
    end else begin
      // broken sequence: random values, random anchor ends
      n = $urandom_range(1, 30);
      for (int i = 0; i < n; i++) add_item(int'($urandom), $urandom_range(5) == 0);
    end
  endtask

  // Sender held off until the block has returned every detection
  task automatic wait_idle();
    while (head_stream.size() != 0 || in_valid_i || pending_dets.size() != 0)
      @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  initial begin
    int target;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: tie on best score, then box-only anchors that fall below threshold
    add_item(320 * 4096, 1'b0);
    add_item(240 * 4096, 1'b0);
    add_item(100 * 4096, 1'b0);
    add_item(50 * 4096, 1'b0);
    add_item(500, 1'b0);
    add_item(3000, 1'b0);
    add_item(3000, 1'b1);
    add_anchor(4, 0, 1);
    add_item(1023, 1'b0);
    add_item(200, 1'b1);
    wait_idle();

    // Zero threshold: class minus one passes; extreme boxes saturate
    load_config('0, 1'b1, '1, '0, '1, '1, '1);
    add_item(8388607, 1'b0);
    add_item(-8388608, 1'b0);
    add_item(-8388608, 1'b0);
    add_item(8388607, 1'b0);
    add_item(-1, 1'b0);
    add_item(0, 1'b1);
    // anchor ending on a box value
    add_item(-8388608, 1'b0);
    add_item(8388607, 1'b1);
    wait_idle();

    // Maximum threshold, zero inverse scale, class masks in use
    load_config('1, 1'b0, '1, '1, '0, '0, '0);
    add_anchor(4, 7, 0);
    add_item(8388607, 1'b1);
    wait_idle();

    for (int k = 0; k < RandPhases; k++) begin
      rand_config();
      no_idle = (k == 1);
      target = gen_count + PhaseItems;
      while (gen_count < target) add_random_anchor();
      wait_idle();
    end
    no_idle = 1'b0;

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: files.f
rtl/dhd_pkg.sv
rtl/dhd_front.sv
rtl/dhd_queue.sv
rtl/dhd_back.sv
rtl/detection_head_decode.sv
tb/testbench.sv
